/* rtl/sdp_pkg.sv */
// Shared types, codes and helpers of the step/direction pulse generator.
package sdp_pkg;

  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned STEPS_W   = 16;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned DIR_W     = 2;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned TRAVEL_W  = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [TIME_W-1:0] ELAPSED_MAX    = 16'hFFFF;
  localparam logic [TIME_W-1:0] TIME_RESET_VAL = 16'd1000;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK         = 3'd0,
    OP_LOAD         = 3'd1,
    OP_ADD          = 3'd2,
    OP_SET_MODE_DIR = 3'd3,
    OP_SET_MODE     = 3'd4,
    OP_SET_DIR      = 3'd5
  } opcode_t;

  localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CONT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BUF  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BAD  = 2'd3;

  localparam logic [DIR_W-1:0] DIR_IDLE = 2'd2;
  localparam logic [DIR_W-1:0] DIR_BAD  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_TIME  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TIME = 1'b1;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [STEPS_W-1:0]  steps;
    logic [MODE_W-1:0]   run_mode;
    logic [DIR_W-1:0]    direction;
    logic                with_direction;
  } cmd_t;

  typedef struct packed {
    logic                step_out;
    logic                dir_out;
    logic [MODE_W-1:0]   mode_now;
    logic [STEPS_W-1:0]  remaining_count;
    logic [STEPS_W-1:0]  scheduled_count;
    logic [TRAVEL_W-1:0] traveled_count;
  } result_t;

  // Map the unused mode code to off.
  function automatic logic [MODE_W-1:0] clean_mode(input logic [MODE_W-1:0] m);
    clean_mode = (m == MODE_BAD) ? MODE_OFF : m;
  endfunction

  // Map the unused direction code to idle.
  function automatic logic [DIR_W-1:0] clean_dir(input logic [DIR_W-1:0] d);
    clean_dir = (d == DIR_BAD) ? DIR_IDLE : d;
  endfunction

endpackage

/* rtl/sdp_cmd_if.sv */
// Command/tick channel: valid, ready and one input item.
interface sdp_cmd_if;
  import sdp_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [STEPS_W-1:0]  steps;
  logic [MODE_W-1:0]   run_mode;
  logic [DIR_W-1:0]    direction;
  logic                with_direction;

  modport source (output valid, opcode, steps, run_mode, direction, with_direction,
                  input ready);
  modport sink (input valid, opcode, steps, run_mode, direction, with_direction,
                output ready);
endinterface

/* rtl/sdp_res_if.sv */
// Result channel: valid, ready and one result item.
interface sdp_res_if;
  import sdp_pkg::*;

  logic                valid;
  logic                ready;
  logic                step_out;
  logic                dir_out;
  logic [MODE_W-1:0]   mode_now;
  logic [STEPS_W-1:0]  remaining_count;
  logic [STEPS_W-1:0]  scheduled_count;
  logic [TRAVEL_W-1:0] traveled_count;

  modport source (output valid, step_out, dir_out, mode_now, remaining_count,
                  scheduled_count, traveled_count, input ready);
  modport sink (input valid, step_out, dir_out, mode_now, remaining_count,
                scheduled_count, traveled_count, output ready);
endinterface

/* rtl/stepper_step_dir_pulser.sv */
// Top level of the step/direction pulse generator: input and result registers around the core.
//
// Usage:
//   cmd    - input channel; each item is a one-microsecond tick (opcode tick) or a
//            command that loads or adds a step budget, or sets mode and/or direction.
//            An item is taken on a clock edge with valid and ready both high.
//   result - output channel; exactly one item per input item, showing the pin levels,
//            mode and counters after that item, in input order.
//   cfg_*  - write port for low_time (index 0) and high_time (index 1); write only
//            while no item is in flight.
// Flow: an item is captured in the input register; when it advances, the core
//   updates its state and the result register loads at the same edge, and the
//   result is offered from the result register until it is taken.
// Throughput: one item per cycle while results are taken; the state update is a single
//   pass through the core and each tick depends only on the state left by the item before it.
// Reset: rst (synchronous, active high) empties both registers, sets the mode to
//   off, the direction to idle, all counters to zero and both times to 1000 ticks.
// Stall: while a result waits, one more item is held in the input register; ready
//   drops only when both are full, so no item is lost or repeated.
module stepper_step_dir_pulser #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  sdp_cmd_if.sink                       cmd,
  sdp_res_if.source                     result,
  input  logic                          cfg_we,
  input  logic [sdp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdp_pkg::TIME_W-1:0]    cfg_data
);
  import sdp_pkg::*;

  logic    in_valid;
  cmd_t    in_item;
  logic    out_valid;
  result_t out_item;
  result_t result_next;
  logic    advance;
  logic    take;
  cmd_t    cmd_item;

  assign cmd_item.opcode         = cmd.opcode;
  assign cmd_item.steps          = cmd.steps;
  assign cmd_item.run_mode       = cmd.run_mode;
  assign cmd_item.direction      = cmd.direction;
  assign cmd_item.with_direction = cmd.with_direction;

  // Advance the held item into the core whenever the result register can take it.
  assign advance   = in_valid && (!out_valid || result.ready);
  assign cmd.ready = !in_valid || advance;
  assign take      = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // Hold the payload until it is advanced.
  always_ff @(posedge clk) begin
    if (take) begin
      in_item <= cmd_item;
    end
  end

  sdp_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (advance),
    .cmd         (in_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result_next;
    end
  end

  assign result.valid           = out_valid;
  assign result.step_out        = out_item.step_out;
  assign result.dir_out         = out_item.dir_out;
  assign result.mode_now        = out_item.mode_now;
  assign result.remaining_count = out_item.remaining_count;
  assign result.scheduled_count = out_item.scheduled_count;
  assign result.traveled_count  = out_item.traveled_count;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> cmd.ready)
    else $error("input stalled with an empty input register");

  a_advance_fills_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item did not reach the result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |-> !advance)
    else $error("pending result overwritten");
`endif

endmodule

/* rtl/sdp_core.sv */
// Pulse generator state, configuration registers and the per-item update.
module sdp_core #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                fire,
  input  sdp_pkg::cmd_t                       cmd,
  input  logic                                cfg_we,
  input  logic [sdp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sdp_pkg::TIME_W-1:0]          cfg_data,
  output sdp_pkg::result_t                    result_next
);
  import sdp_pkg::*;

  localparam int unsigned SUM_W = ((COUNT_BITS > STEPS_W) ? COUNT_BITS : STEPS_W) + 1;
  localparam logic [SUM_W-1:0] COUNT_MAX = SUM_W'({COUNT_BITS{1'b1}});

  logic [TIME_W-1:0]     low_time;
  logic [TIME_W-1:0]     high_time;
  logic                  step_level;
  logic                  dir_level;
  logic [MODE_W-1:0]     mode_reg;
  logic [DIR_W-1:0]      dir_setting;
  logic [COUNT_BITS-1:0] scheduled_reg;
  logic [COUNT_BITS-1:0] remaining_reg;
  logic [TRAVEL_W-1:0]   traveled_reg;
  logic [TIME_W-1:0]     elapsed_ticks;

  logic                  step_level_next;
  logic                  dir_level_next;
  logic [MODE_W-1:0]     mode_reg_next;
  logic [DIR_W-1:0]      dir_setting_next;
  logic [COUNT_BITS-1:0] scheduled_reg_next;
  logic [COUNT_BITS-1:0] remaining_reg_next;
  logic [TRAVEL_W-1:0]   traveled_reg_next;
  logic [TIME_W-1:0]     elapsed_ticks_next;

  logic [TIME_W-1:0]     elapsed_inc;
  logic [SUM_W-1:0]      sum_base;
  logic [SUM_W-1:0]      sum;
  logic [COUNT_BITS-1:0] budget_sat;
  logic [SUM_W-1:0]      remaining_wide;
  logic [SUM_W-1:0]      scheduled_wide;

  assign elapsed_inc = (elapsed_ticks < ELAPSED_MAX) ? elapsed_ticks + 1'b1 : elapsed_ticks;

  // Load starts from zero, add from the current budget; clamp at the counter top.
  assign sum_base   = (cmd.opcode == OP_LOAD) ? '0 : SUM_W'(scheduled_reg);
  assign sum        = sum_base + SUM_W'(cmd.steps);
  assign budget_sat = (sum > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0] : sum[COUNT_BITS-1:0];

  always_comb begin
    step_level_next    = step_level;
    dir_level_next     = dir_level;
    mode_reg_next      = mode_reg;
    dir_setting_next   = dir_setting;
    scheduled_reg_next = scheduled_reg;
    remaining_reg_next = remaining_reg;
    traveled_reg_next  = traveled_reg;
    elapsed_ticks_next = elapsed_ticks;
    case (cmd.opcode)
      OP_TICK: begin
        elapsed_ticks_next = elapsed_inc;
        if (dir_setting != DIR_IDLE) begin
          dir_level_next = dir_setting[0];
          if (step_level) begin
            if (elapsed_inc >= high_time) begin
              step_level_next    = 1'b0;
              elapsed_ticks_next = '0;
            end
          end else if (elapsed_inc >= low_time) begin
            if (mode_reg == MODE_CONT) begin
              step_level_next    = 1'b1;
              traveled_reg_next  = traveled_reg + 1'b1;
              elapsed_ticks_next = '0;
            end else if (mode_reg == MODE_BUF) begin
              if (remaining_reg == '0) begin
                mode_reg_next = MODE_OFF;
              end else begin
                step_level_next    = 1'b1;
                traveled_reg_next  = traveled_reg + 1'b1;
                elapsed_ticks_next = '0;
                remaining_reg_next = remaining_reg - 1'b1;
              end
            end
          end
        end
      end
      OP_LOAD, OP_ADD: begin
        scheduled_reg_next = budget_sat;
        remaining_reg_next = budget_sat;
        if (cmd.with_direction) begin
          mode_reg_next    = MODE_BUF;
          dir_setting_next = clean_dir(cmd.direction);
        end
      end
      OP_SET_MODE_DIR: begin
        mode_reg_next      = clean_mode(cmd.run_mode);
        dir_setting_next   = clean_dir(cmd.direction);
        remaining_reg_next = scheduled_reg;
      end
      OP_SET_MODE: begin
        mode_reg_next = clean_mode(cmd.run_mode);
      end
      OP_SET_DIR: begin
        dir_setting_next = clean_dir(cmd.direction);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_level    <= 1'b0;
      dir_level     <= 1'b0;
      mode_reg      <= MODE_OFF;
      dir_setting   <= DIR_IDLE;
      scheduled_reg <= '0;
      remaining_reg <= '0;
      traveled_reg  <= '0;
      elapsed_ticks <= '0;
    end else if (fire) begin
      step_level    <= step_level_next;
      dir_level     <= dir_level_next;
      mode_reg      <= mode_reg_next;
      dir_setting   <= dir_setting_next;
      scheduled_reg <= scheduled_reg_next;
      remaining_reg <= remaining_reg_next;
      traveled_reg  <= traveled_reg_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_time  <= TIME_RESET_VAL;
      high_time <= TIME_RESET_VAL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOW_TIME:  low_time  <= cfg_data;
        CFG_HIGH_TIME: high_time <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign remaining_wide = SUM_W'(remaining_reg_next);
  assign scheduled_wide = SUM_W'(scheduled_reg_next);

  assign result_next.step_out        = step_level_next;
  assign result_next.dir_out         = dir_level_next;
  assign result_next.mode_now        = mode_reg_next;
  assign result_next.remaining_count = remaining_wide[STEPS_W-1:0];
  assign result_next.scheduled_count = scheduled_wide[STEPS_W-1:0];
  assign result_next.traveled_count  = traveled_reg_next;

`ifndef SYNTHESIS
  a_remaining_le_scheduled: assert property (@(posedge clk) disable iff (rst)
    remaining_reg <= scheduled_reg)
    else $error("remaining budget exceeds scheduled budget");

  a_travel_only_on_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (traveled_reg != $past(traveled_reg)) |-> $rose(step_level))
    else $error("travel count moved without a step edge");

  a_dir_idle_holds_pins: assert property (@(posedge clk) disable iff (rst)
    fire && dir_setting == DIR_IDLE |=> $stable(step_level) && $stable(dir_level))
    else $error("pins changed while direction is idle");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench of the step/direction pulse generator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sdp_pkg::*;

  // Direction codes that the package leaves unnamed, and the two spare opcodes.
  localparam logic [DIR_W-1:0]    DIR_REV      = 2'd0;
  localparam logic [DIR_W-1:0]    DIR_FWD      = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO  = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI  = 3'd7;
  localparam logic [STEPS_W-1:0]  STEPS_MAX    = 16'hFFFF;
  localparam logic [TIME_W-1:0]   TIME_MAX     = 16'hFFFF;
  localparam int                  CYCLE_LIMIT  = 2_000_000;
  // Long receiver hold-off: starts once this many items went in, lasts this long.
  localparam int                  STALL_AT     = 500;
  localparam int                  STALL_CYCLES = 400;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_LOW_TIME;
  logic [TIME_W-1:0]    cfg_data = '0;

  sdp_cmd_if cmd_ch ();
  sdp_res_if res_ch ();

  stepper_step_dir_pulser dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .result    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Items waiting to be offered, and the pulser snapshots expected back, oldest first.
  cmd_t    cmd_q[$];
  result_t snapshot_q[$];
  cmd_t    offered;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_accepted    = 0;
  int n_checked     = 0;
  int n_fail        = 0;
  int n_settings    = 0;
  int stall_left    = 0;
  bit stall_done    = 1'b0;
  int cycles        = 0;

  // Predicted pulser state and timing registers.
  logic                 p_step;
  logic                 p_dir;
  logic [MODE_W-1:0]    p_mode;
  logic [DIR_W-1:0]     p_dir_sel;
  logic [STEPS_W-1:0]   p_sched;
  logic [STEPS_W-1:0]   p_remain;
  logic [TRAVEL_W-1:0]  p_travel;
  logic [TIME_W-1:0]    p_elapsed;
  logic [TIME_W-1:0]    p_low;
  logic [TIME_W-1:0]    p_high;

  function automatic logic [MODE_W-1:0] fold_mode(logic [MODE_W-1:0] m);
    return (m == MODE_BAD) ? MODE_OFF : m;
  endfunction

  function automatic logic [DIR_W-1:0] fold_dir(logic [DIR_W-1:0] d);
    return (d == DIR_BAD) ? DIR_IDLE : d;
  endfunction

  task automatic fire_step();
    p_step    = 1'b1;
    p_travel  = p_travel + 1'b1;
    p_elapsed = '0;
  endtask

  // One microsecond tick: age the phase, then move the pins unless idle.
  task automatic tick_pulser();
    if (p_elapsed != ELAPSED_MAX) p_elapsed = p_elapsed + 1'b1;
    if (p_dir_sel == DIR_IDLE) return;
    p_dir = p_dir_sel[0];
    if (p_step) begin
      if (p_elapsed >= p_high) begin
        p_step    = 1'b0;
        p_elapsed = '0;
      end
    end else if (p_elapsed >= p_low) begin
      if (p_mode == MODE_CONT) begin
        fire_step();
      end else if (p_mode == MODE_BUF) begin
        // Empty budget at the end of the low phase: drop to off, elapsed kept.
        if (p_remain == '0) begin
          p_mode = MODE_OFF;
        end else begin
          fire_step();
          p_remain = p_remain - 1'b1;
        end
      end
    end
  endtask

  // Apply one accepted item and queue the snapshot it must produce.
  task automatic advance_pulser(cmd_t c);
    logic [STEPS_W:0] sum;
    result_t          snap;
    case (c.opcode)
      OP_TICK: tick_pulser();
      OP_LOAD, OP_ADD: begin
        // Add saturates at the counter maximum; the budget reloads remaining.
        sum      = (c.opcode == OP_LOAD) ? {1'b0, c.steps} : p_sched + c.steps;
        p_sched  = sum[STEPS_W] ? STEPS_MAX : sum[STEPS_W-1:0];
        p_remain = p_sched;
        if (c.with_direction) begin
          p_mode    = MODE_BUF;
          p_dir_sel = fold_dir(c.direction);
        end
      end
      OP_SET_MODE_DIR: begin
        p_mode    = fold_mode(c.run_mode);
        p_dir_sel = fold_dir(c.direction);
        p_remain  = p_sched;
      end
      OP_SET_MODE: p_mode = fold_mode(c.run_mode);
      OP_SET_DIR:  p_dir_sel = fold_dir(c.direction);
      default: ;  // spare opcodes leave everything as it is
    endcase
    snap.step_out        = p_step;
    snap.dir_out         = p_dir;
    snap.mode_now        = p_mode;
    snap.remaining_count = p_remain;
    snap.scheduled_count = p_sched;
    snap.traveled_count  = p_travel;
    snapshot_q.push_back(snap);
  endtask

  task automatic queue_cmd(logic [OPCODE_W-1:0] op, logic [STEPS_W-1:0] steps,
                           logic [MODE_W-1:0] mode, logic [DIR_W-1:0] dir, logic wd);
    cmd_t c;
    c.opcode         = op;
    c.steps          = steps;
    c.run_mode       = mode;
    c.direction      = dir;
    c.with_direction = wd;
    cmd_q.push_back(c);
  endtask

  task automatic queue_ticks(int n);
    repeat (n) queue_cmd(OP_TICK, $urandom, $urandom, $urandom, $urandom);
  endtask

  function automatic logic [STEPS_W-1:0] pick_steps();
    case ($urandom_range(3))
      0:       return $urandom_range(4);
      1:       return STEPS_MAX - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  // Mostly a command followed by a run of ticks; now and then a spare opcode as noise.
  task automatic queue_random(int n_items);
    int                  made;
    int                  pick;
    int                  run;
    logic [DIR_W-1:0]    dir;
    logic [OPCODE_W-1:0] op;
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(99);
      dir  = ($urandom_range(9) < 7) ? DIR_W'($urandom_range(1)) : DIR_W'($urandom_range(3));
      if (pick < 30)      op = OP_LOAD;
      else if (pick < 48) op = OP_ADD;
      else if (pick < 66) op = OP_SET_MODE_DIR;
      else if (pick < 78) op = OP_SET_MODE;
      else if (pick < 92) op = OP_SET_DIR;
      else                op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
      queue_cmd(op, pick_steps(), $urandom_range(3), dir, $urandom_range(9) < 7);
      if (op != OP_SPARE_LO && op != OP_SPARE_HI) made++;
      run = $urandom_range(14);
      queue_ticks(run);
      made += run;
    end
  endtask

  // Hold new items back until everything offered has come out, then let the core settle.
  task automatic drain();
    do @(negedge clk);
    while (cmd_q.size() != 0 || cmd_ch.valid || snapshot_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LOW_TIME) p_low = val;
    else                     p_high = val;
    @(negedge clk);
  endtask

  task automatic set_times(logic [TIME_W-1:0] low_t, logic [TIME_W-1:0] high_t);
    write_reg(CFG_LOW_TIME, low_t);
    write_reg(CFG_HIGH_TIME, high_t);
    n_settings++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  // Driver: offer the next pending item, hold it until taken, idle at random.
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        advance_pulser(offered);
        n_accepted <= n_accepted + 1;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered                = cmd_q.pop_front();
          cmd_ch.valid          <= 1'b1;
          cmd_ch.opcode         <= offered.opcode;
          cmd_ch.steps          <= offered.steps;
          cmd_ch.run_mode       <= offered.run_mode;
          cmd_ch.direction      <= offered.direction;
          cmd_ch.with_direction <= offered.with_direction;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once, so the block fills up and drops ready.
  always @(posedge clk) begin
    if (!stall_done && n_accepted >= STALL_AT) begin
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Monitor: stall at random and compare each taken result with the oldest snapshot.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      if (res_ch.valid && res_ch.ready) begin
        n_checked <= n_checked + 1;
        if (snapshot_q.size() == 0) begin
          $error("result with no item waiting for it");
          n_fail++;
        end else begin
          result_t want;
          want = snapshot_q.pop_front();
          check_field("step_out", want.step_out, res_ch.step_out);
          check_field("dir_out", want.dir_out, res_ch.dir_out);
          check_field("mode_now", want.mode_now, res_ch.mode_now);
          check_field("remaining_count", want.remaining_count, res_ch.remaining_count);
          check_field("scheduled_count", want.scheduled_count, res_ch.scheduled_count);
          check_field("traveled_count", want.traveled_count, res_ch.traveled_count);
        end
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL stepper_step_dir_pulser");
      $finish;
    end
  end

  initial begin
    cmd_ch.valid          = 1'b0;
    cmd_ch.opcode         = OP_TICK;
    cmd_ch.steps          = '0;
    cmd_ch.run_mode       = MODE_OFF;
    cmd_ch.direction      = DIR_IDLE;
    cmd_ch.with_direction = 1'b0;
    res_ch.ready          = 1'b0;
    p_step    = 1'b0;
    p_dir     = 1'b0;
    p_mode    = MODE_OFF;
    p_dir_sel = DIR_IDLE;
    p_sched   = '0;
    p_remain  = '0;
    p_travel  = '0;
    p_elapsed = '0;
    p_low     = TIME_RESET_VAL;
    p_high    = TIME_RESET_VAL;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset times: direction follows, but no step within a handful of ticks.
    send_idle_pct = 8;
    recv_idle_pct = 68;
    queue_ticks(1);
    queue_cmd(OP_SET_DIR, 0, MODE_OFF, DIR_FWD, 1'b0);
    queue_cmd(OP_SET_MODE, 0, MODE_CONT, DIR_IDLE, 1'b0);
    queue_ticks(2);
    queue_cmd(OP_SPARE_HI, STEPS_MAX, MODE_BAD, DIR_BAD, 1'b1);
    drain();

    // Zero-length phases: every tick with a direction set drops a high pin, or steps when the mode and budget allow.
    set_times('0, '0);
    queue_cmd(OP_SET_DIR, 0, MODE_OFF, DIR_BAD, 1'b0);            // folds to idle
    queue_cmd(OP_SET_MODE, 0, MODE_CONT, DIR_IDLE, 1'b0);
    queue_ticks(1);                                               // idle: pins stay
    queue_cmd(OP_LOAD, 0, MODE_OFF, DIR_FWD, 1'b1);               // buffered, empty
    queue_ticks(1);                                               // falls to off
    queue_cmd(OP_LOAD, 3, MODE_OFF, DIR_REV, 1'b1);
    queue_ticks(7);                                               // three steps, then off
    queue_cmd(OP_LOAD, STEPS_MAX, MODE_OFF, DIR_FWD, 1'b0);
    queue_cmd(OP_ADD, 5, MODE_OFF, DIR_BAD, 1'b1);                // saturates, idle dir
    queue_cmd(OP_SET_MODE, 0, MODE_BAD, DIR_IDLE, 1'b0);          // folds to off
    queue_cmd(OP_SET_MODE_DIR, 0, MODE_CONT, DIR_FWD, 1'b0);
    queue_ticks(3);
    queue_cmd(OP_SET_MODE_DIR, 0, MODE_BAD, DIR_BAD, 1'b0);
    queue_cmd(OP_SPARE_LO, STEPS_MAX, MODE_BUF, DIR_FWD, 1'b1);
    queue_cmd(OP_SET_DIR, 0, MODE_OFF, DIR_REV, 1'b0);
    queue_ticks(1);
    drain();

    set_times(1, 2);
    queue_random(350);
    drain();

    // Swap the idle odds: a busy receiver and a sparse sender.
    send_idle_pct = 68;
    recv_idle_pct = 8;
    set_times(3, 1);
    queue_random(350);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_times($urandom_range(4), $urandom_range(4));
    queue_random(300);
    drain();

    // Longest high phase: once the pin goes up it stays there.
    set_times(2, TIME_MAX);
    queue_random(40);
    drain();

    // Longest low phase: the pin, once low, stays low in off mode and in continuous mode alike.
    set_times(TIME_MAX, '0);
    queue_cmd(OP_SET_MODE_DIR, 0, MODE_OFF, DIR_FWD, 1'b0);
    queue_ticks(20);
    queue_cmd(OP_SET_MODE, 0, MODE_CONT, DIR_IDLE, 1'b0);
    queue_ticks(3);
    drain();

    repeat (8) @(posedge clk);
    $display("Run covered %0d items and %0d results over %0d timing settings,",
             n_accepted, n_checked, n_settings);
    $display("all opcodes, folded codes, budget saturation and %0d predicted steps.",
             p_travel);
    if (n_fail == 0 && snapshot_q.size() == 0) begin
      $display("PASS stepper_step_dir_pulser");
    end else begin
      $display("FAIL stepper_step_dir_pulser");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sdp_pkg.sv
rtl/sdp_cmd_if.sv
rtl/sdp_res_if.sv
rtl/sdp_core.sv
rtl/stepper_step_dir_pulser.sv
tb/tb.sv
